// ===== sv/apbc_pkg.sv =====
// Shared package for the audio playback buffer controller.
// Holds command codes, playback modes, status codes, widths and the
// controller-to-datapath command type. No dependencies.
package apbc_pkg;

   localparam int RING_DEPTH_DEFAULT  = 4096;
   localparam int CHANNELS_DEFAULT    = 2;
   localparam int SAMPLE_BITS_DEFAULT = 32;

   localparam int KIND_W   = 4;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 48;
   localparam int CNT_W    = 13;
   localparam int STATUS_W = 3;
   localparam int MODE_W   = 3;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 216;

   localparam logic [KIND_W-1:0] KIND_WRITE    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_RENDER   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_PLAY     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_PAUSE    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_STOP     = 4'd4;
   localparam logic [KIND_W-1:0] KIND_SEEK     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_SRC_END  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_CHAIN    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_TAKE_X   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_FAULT    = 4'd9;

   localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FAILED      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE       = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_IGNORED     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_NO_CROSSING = 3'd5;

   localparam logic [MODE_W-1:0] MODE_STOPPED   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BUFFERING = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PLAYING   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DRAINING  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PAUSED    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ENDED     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_FAILED    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_POS   = 2'd3;

   localparam logic [CNT_W-1:0] CAPACITY_RESET  = 13'd4096;
   localparam logic [CNT_W-1:0] THRESHOLD_RESET = 13'd1024;
   localparam logic [POS_W-1:0] START_POS_RESET = '0;
   localparam logic [POS_W-1:0] END_POS_UNKNOWN = '1;

   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

endpackage

// ===== sv/apbc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the frame ring. No dependencies.
module apbc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/apbc_ctrl.sv =====
// Sequencer for the playback buffer: takes a beat, waits for the ring read,
// then commits the item into the result register. Depends on apbc_pkg.
module apbc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output apbc_pkg::cmd_type cmd
);

   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic load, commit;

   assign req_tready = (state_ff == FSM_IDLE);
   assign load       = req_tvalid && req_tready;
   assign commit     = (state_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (load) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (commit) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign cmd.load   = load;
   assign cmd.commit = commit;

endmodule

// ===== sv/apbc_datapath.sv =====
// Datapath of the playback buffer: configuration registers, ring pointers,
// playback mode, positions and the result register. Depends on apbc_pkg, apbc_ram.
module apbc_datapath #(
   parameter int RING_DEPTH  = apbc_pkg::RING_DEPTH_DEFAULT,
   parameter int CHANNELS    = apbc_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = apbc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  apbc_pkg::cmd_type               cmd,
   input  logic [apbc_pkg::KIND_W-1:0]     req_kind,
   input  logic [apbc_pkg::WORD_W-1:0]     req_sample_ch0,
   input  logic [apbc_pkg::WORD_W-1:0]     req_sample_ch1,
   input  logic [apbc_pkg::POS_W-1:0]      req_target_position,
   input  logic                            csr_we,
   input  logic [apbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [apbc_pkg::POS_W-1:0]      csr_data,
   output logic [apbc_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_frame_valid,
   output logic [apbc_pkg::WORD_W-1:0]     rsp_out_ch0,
   output logic [apbc_pkg::WORD_W-1:0]     rsp_out_ch1,
   output logic [apbc_pkg::MODE_W-1:0]     rsp_play_state,
   output logic [apbc_pkg::CNT_W-1:0]      rsp_fill_level,
   output logic [apbc_pkg::POS_W-1:0]      rsp_play_position,
   output logic [apbc_pkg::WORD_W-1:0]     rsp_underruns,
   output logic                            rsp_crossing_valid,
   output logic [apbc_pkg::POS_W-1:0]      rsp_crossing_position
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int MEM_W = CHANNELS * SAMPLE_BITS;
   localparam int CNT_W = apbc_pkg::CNT_W;
   localparam int POS_W = apbc_pkg::POS_W;
   localparam int WORD_W = apbc_pkg::WORD_W;
   localparam int MODE_W = apbc_pkg::MODE_W;
   localparam int STATUS_W = apbc_pkg::STATUS_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   // Configuration registers.
   logic [CNT_W-1:0] cap_ff, thr_ff;
   logic [POS_W-1:0] start_pos_ff, end_pos_ff;

   // Latched item.
   logic [apbc_pkg::KIND_W-1:0] kind_ff;
   logic [WORD_W-1:0]           s0_ff, s1_ff;
   logic [POS_W-1:0]            target_ff;

   // Playback state.
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              done_ff, done_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in, ppos_ff, ppos_in, bpos_ff, bpos_in;
   logic [WORD_W-1:0] und_ff, und_in;
   logic              bset_ff, bset_in, bcross_ff, bcross_in;

   // Result register.
   logic [STATUS_W-1:0] status_ff;
   logic                fv_ff, cv_ff;
   logic [WORD_W-1:0]   o0_ff, o1_ff;
   logic [MODE_W-1:0]   ps_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [POS_W-1:0]    pos_ff, cpos_ff;
   logic [WORD_W-1:0]   undo_ff;

   logic [STATUS_W-1:0] status;
   logic                fv, cv, we, clr, running;
   logic [POS_W-1:0]    cpos, clr_pos;
   logic [CNT_W-1:0]    eff_cap, eff_thr;
   logic [MEM_W-1:0]    wr_data, rd_data;
   logic [WORD_W-1:0]   o0, o1;

   apbc_ram #(
      .WIDTH (MEM_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.load),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      eff_cap = (cap_ff == '0) ? CNT_W'(1) : cap_ff;
      if (32'(eff_cap) > RING_DEPTH) eff_cap = CNT_W'(RING_DEPTH);
      eff_thr = (thr_ff == '0) ? CNT_W'(1) : thr_ff;
      if (eff_thr > eff_cap) eff_thr = eff_cap;
   end

   assign running = mode_ff inside {apbc_pkg::MODE_BUFFERING, apbc_pkg::MODE_PLAYING,
                                    apbc_pkg::MODE_DRAINING};

   always_comb begin
      wr_data = MEM_W'(s0_ff[SAMPLE_BITS-1:0]);
      if (CHANNELS >= 2) wr_data = MEM_W'({s1_ff[SAMPLE_BITS-1:0], s0_ff[SAMPLE_BITS-1:0]});
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      mode_in   = mode_ff;
      done_in   = done_ff;
      rpos_in   = rpos_ff;
      ppos_in   = ppos_ff;
      bpos_in   = bpos_ff;
      und_in    = und_ff;
      bset_in   = bset_ff;
      bcross_in = bcross_ff;
      status    = apbc_pkg::STAT_OK;
      fv        = 1'b0;
      cv        = 1'b0;
      cpos      = '0;
      we        = 1'b0;
      clr       = 1'b0;
      clr_pos   = start_pos_ff;
      if (cmd.commit) begin
         case (kind_ff)
            apbc_pkg::KIND_WRITE: begin
               if (!running || done_ff) begin
                  status = apbc_pkg::STAT_IGNORED;
               end else if (count_ff >= eff_cap) begin
                  status = apbc_pkg::STAT_FULL;
               end else begin
                  we        = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
                  count_in  = count_ff + CNT_W'(1);
                  ppos_in   = ppos_ff + POS_W'(1);
                  if (mode_ff == apbc_pkg::MODE_BUFFERING && count_in >= eff_thr) begin
                     mode_in = apbc_pkg::MODE_PLAYING;
                  end
               end
            end
            apbc_pkg::KIND_RENDER: begin
               if (mode_ff != apbc_pkg::MODE_PLAYING && mode_ff != apbc_pkg::MODE_DRAINING) begin
                  status = apbc_pkg::STAT_IGNORED;
               end else begin
                  if (count_ff != '0) begin
                     fv        = 1'b1;
                     rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
                     count_in  = count_ff - CNT_W'(1);
                     rpos_in   = rpos_ff + POS_W'(1);
                  end
                  if (bset_ff && rpos_in >= bpos_ff) bcross_in = 1'b1;
                  if (!fv) begin
                     if (mode_ff == apbc_pkg::MODE_PLAYING) begin
                        if (und_ff != '1) und_in = und_ff + WORD_W'(1);
                        mode_in = apbc_pkg::MODE_BUFFERING;
                     end else begin
                        mode_in = apbc_pkg::MODE_ENDED;
                     end
                  end else if (mode_ff == apbc_pkg::MODE_DRAINING && count_in == '0) begin
                     mode_in = apbc_pkg::MODE_ENDED;
                  end
               end
            end
            apbc_pkg::KIND_PLAY: begin
               if (mode_ff == apbc_pkg::MODE_FAILED) begin
                  status = apbc_pkg::STAT_FAILED;
               end else if (!running) begin
                  if (mode_ff == apbc_pkg::MODE_ENDED) begin
                     // After the implied stop the ring is empty and the source is live.
                     clr     = 1'b1;
                     mode_in = apbc_pkg::MODE_BUFFERING;
                  end else if (done_ff) begin
                     mode_in = (count_ff == '0) ? apbc_pkg::MODE_ENDED : apbc_pkg::MODE_DRAINING;
                  end else begin
                     mode_in = (count_ff >= eff_thr) ? apbc_pkg::MODE_PLAYING
                                                     : apbc_pkg::MODE_BUFFERING;
                  end
               end
            end
            apbc_pkg::KIND_PAUSE: begin
               if (running) mode_in = apbc_pkg::MODE_PAUSED;
               else status = apbc_pkg::STAT_IGNORED;
            end
            apbc_pkg::KIND_STOP: begin
               clr     = 1'b1;
               mode_in = apbc_pkg::MODE_STOPPED;
            end
            apbc_pkg::KIND_SEEK: begin
               if (mode_ff == apbc_pkg::MODE_FAILED) begin
                  status = apbc_pkg::STAT_FAILED;
               end else if (target_ff < start_pos_ff ||
                            (end_pos_ff != apbc_pkg::END_POS_UNKNOWN && target_ff > end_pos_ff)) begin
                  status = apbc_pkg::STAT_RANGE;
               end else begin
                  if (mode_ff != apbc_pkg::MODE_PAUSED && mode_ff != apbc_pkg::MODE_STOPPED) begin
                     mode_in = apbc_pkg::MODE_BUFFERING;
                  end
                  clr     = 1'b1;
                  clr_pos = target_ff;
               end
            end
            apbc_pkg::KIND_SRC_END: begin
               if (!running || done_ff) begin
                  status = apbc_pkg::STAT_IGNORED;
               end else begin
                  done_in = 1'b1;
                  mode_in = (count_ff == '0) ? apbc_pkg::MODE_ENDED : apbc_pkg::MODE_DRAINING;
               end
            end
            apbc_pkg::KIND_CHAIN: begin
               if (mode_ff == apbc_pkg::MODE_FAILED || bset_ff || done_ff) begin
                  status = apbc_pkg::STAT_FAILED;
               end else begin
                  bpos_in   = ppos_ff;
                  bset_in   = 1'b1;
                  bcross_in = 1'b0;
               end
            end
            apbc_pkg::KIND_TAKE_X: begin
               if (bcross_ff && bset_ff) begin
                  cv        = 1'b1;
                  cpos      = bpos_ff;
                  bcross_in = 1'b0;
                  bset_in   = 1'b0;
                  bpos_in   = '0;
               end else begin
                  status = apbc_pkg::STAT_NO_CROSSING;
               end
            end
            apbc_pkg::KIND_FAULT: begin
               mode_in = apbc_pkg::MODE_FAILED;
            end
            default: begin
               status = apbc_pkg::STAT_IGNORED;
            end
         endcase
         if (clr) begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            count_in  = '0;
            done_in   = 1'b0;
            bpos_in   = '0;
            bset_in   = 1'b0;
            bcross_in = 1'b0;
            rpos_in   = clr_pos;
            ppos_in   = clr_pos;
         end
      end
   end

   always_comb begin
      o0 = '0;
      o1 = '0;
      if (fv) begin
         o0 = WORD_W'(rd_data[SAMPLE_BITS-1:0]);
         if (CHANNELS >= 2) o1 = WORD_W'(rd_data[MEM_W-1 -: SAMPLE_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= apbc_pkg::CAPACITY_RESET;
         thr_ff       <= apbc_pkg::THRESHOLD_RESET;
         start_pos_ff <= apbc_pkg::START_POS_RESET;
         end_pos_ff   <= apbc_pkg::END_POS_UNKNOWN;
      end else if (csr_we) begin
         case (csr_index)
            apbc_pkg::CSR_CAPACITY:  cap_ff       <= csr_data[CNT_W-1:0];
            apbc_pkg::CSR_THRESHOLD: thr_ff       <= csr_data[CNT_W-1:0];
            apbc_pkg::CSR_START_POS: start_pos_ff <= csr_data;
            apbc_pkg::CSR_END_POS:   end_pos_ff   <= csr_data;
            default: cap_ff <= cap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
         mode_ff   <= apbc_pkg::MODE_STOPPED;
         done_ff   <= 1'b0;
         rpos_ff   <= apbc_pkg::START_POS_RESET;
         ppos_ff   <= apbc_pkg::START_POS_RESET;
         bpos_ff   <= '0;
         und_ff    <= '0;
         bset_ff   <= 1'b0;
         bcross_ff <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         done_ff   <= done_in;
         rpos_ff   <= rpos_in;
         ppos_ff   <= ppos_in;
         bpos_ff   <= bpos_in;
         und_ff    <= und_in;
         bset_ff   <= bset_in;
         bcross_ff <= bcross_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         s0_ff     <= req_sample_ch0;
         s1_ff     <= req_sample_ch1;
         target_ff <= req_target_position;
      end
      if (cmd.commit) begin
         status_ff <= status;
         fv_ff     <= fv;
         o0_ff     <= o0;
         o1_ff     <= o1;
         ps_ff     <= mode_in;
         fill_ff   <= count_in;
         pos_ff    <= rpos_in;
         undo_ff   <= und_in;
         cv_ff     <= cv;
         cpos_ff   <= cpos;
      end
   end

   assign rsp_status            = status_ff;
   assign rsp_frame_valid       = fv_ff;
   assign rsp_out_ch0           = o0_ff;
   assign rsp_out_ch1           = o1_ff;
   assign rsp_play_state        = ps_ff;
   assign rsp_fill_level        = fill_ff;
   assign rsp_play_position     = pos_ff;
   assign rsp_underruns         = undo_ff;
   assign rsp_crossing_valid    = cv_ff;
   assign rsp_crossing_position = cpos_ff;

endmodule

// ===== sv/audio_playback_buffer_controller_core.sv =====
// Top level of the audio playback buffer controller: frame ring with playback control.
// Depends on apbc_pkg, apbc_ctrl, apbc_datapath (which holds apbc_ram).
//
//   channel  | direction | handshake              | payload
//   req      | in        | req_tvalid/req_tready  | req_tdata, req_tuser (one command)
//   rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata, rsp_tuser (one result)
//   csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// Each beat first reads the frame ring, then commits the result once the result slot is free,
// an order set by the registered read port of the ring memory.
// A new beat is taken while the previous result waits; its commit waits for the slot.
// Reset is synchronous; the ring memory is not cleared and needs no clearing pass.
// csr_ready is always high.
module audio_playback_buffer_controller_core #(
   parameter int RING_DEPTH  = apbc_pkg::RING_DEPTH_DEFAULT,
   parameter int CHANNELS    = apbc_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = apbc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: sample_ch0[31:0], sample_ch1[63:32], target_position[111:64].
   input  logic [apbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0: kind[3:0].
   input  logic [apbc_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: frame_valid[0], out_ch0[32:1], out_ch1[64:33], play_state[67:65],
   // fill_level[80:68], play_position[128:81], underruns[160:129], crossing_valid[161],
   // crossing_position[209:162], zero fill[215:210].
   output logic [apbc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Fields from bit 0: status[2:0].
   output logic [apbc_pkg::STATUS_W-1:0]     rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [apbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [apbc_pkg::POS_W-1:0]        csr_data
);

   apbc_pkg::cmd_type cmd;

   logic                            frame_valid, crossing_valid;
   logic [apbc_pkg::WORD_W-1:0]     out_ch0, out_ch1, underruns;
   logic [apbc_pkg::MODE_W-1:0]     play_state;
   logic [apbc_pkg::CNT_W-1:0]      fill_level;
   logic [apbc_pkg::POS_W-1:0]      play_position, crossing_position;

   assign csr_ready = 1'b1;

   apbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   apbc_datapath #(
      .RING_DEPTH  (RING_DEPTH),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_kind              (req_tuser),
      .req_sample_ch0        (req_tdata[31:0]),
      .req_sample_ch1        (req_tdata[63:32]),
      .req_target_position   (req_tdata[111:64]),
      .csr_we                (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_status            (rsp_tuser),
      .rsp_frame_valid       (frame_valid),
      .rsp_out_ch0           (out_ch0),
      .rsp_out_ch1           (out_ch1),
      .rsp_play_state        (play_state),
      .rsp_fill_level        (fill_level),
      .rsp_play_position     (play_position),
      .rsp_underruns         (underruns),
      .rsp_crossing_valid    (crossing_valid),
      .rsp_crossing_position (crossing_position)
   );

   assign rsp_tdata = {6'd0, crossing_position, crossing_valid, underruns, play_position,
                       fill_level, play_state, out_ch1, out_ch0, frame_valid};

endmodule
